// ===== hw/rtl/station_temperature_line_parser_assert.svh =====
// Assertion macros used by the checker of the line parser.
`ifndef STATION_TEMPERATURE_LINE_PARSER_ASSERT_SVH
`define STATION_TEMPERATURE_LINE_PARSER_ASSERT_SVH

// A property checked at every clock edge outside of reset.
`define STLP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("line parser assertion failed");

// A property checked at every clock edge, reset included.
`define STLP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("line parser assertion failed");

`endif

// ===== hw/rtl/stlp_pkg.sv =====
`default_nettype none

package stlp_pkg;

   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned RESULT_DEPTH = 2;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_RETURN  = 8'h0D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [9:0] MAG_MAX = 10'd999;

   typedef logic [2:0] cls_type;

   localparam cls_type CLS_OTHER   = 3'd0;
   localparam cls_type CLS_NEWLINE = 3'd1;
   localparam cls_type CLS_SEMI    = 3'd2;
   localparam cls_type CLS_MINUS   = 3'd3;
   localparam cls_type CLS_DOT     = 3'd4;
   localparam cls_type CLS_DIGIT   = 3'd5;

   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } item_type;

   typedef struct packed {
      logic [63:0]        name_hash;
      logic [7:0]         name_length;
      logic signed [10:0] temp_tenths;
   } result_type;

   function automatic cls_type classify(input logic [7:0] b);
      cls_type c;
      c = CLS_OTHER;
      if (b == CHAR_NEWLINE) begin
         c = CLS_NEWLINE;
      end else if (b == CHAR_SEMI) begin
         c = CLS_SEMI;
      end else if (b == CHAR_MINUS) begin
         c = CLS_MINUS;
      end else if (b == CHAR_DOT) begin
         c = CLS_DOT;
      end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         c = CLS_DIGIT;
      end
      return c;
   endfunction

   function automatic logic [9:0] mag_push(input logic [9:0] mag, input logic [3:0] digit);
      logic [13:0] v;
      v = (14'(mag) << 3) + (14'(mag) << 1) + 14'(digit);
      return (v > 14'(MAG_MAX)) ? MAG_MAX : v[9:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/station_temperature_line_parser.sv =====
// Parses a byte stream of lines "name;[-]d.d" or "name;[-]dd.d" ended by a newline and
// returns, for each line, a base-31 hash of the name, its length saturated at 255 and the
// temperature in signed tenths. One request byte is taken every cycle while req_full is low;
// a front stage classifies each byte and drops carriage returns, a request queue of
// QUEUE_DEPTH entries decouples it from the back stage, which folds one byte per cycle into
// the line state unless a newline waits on a full result queue. Results are registered in
// a result queue of RESULT_DEPTH entries that lets parsing continue while results wait.
`default_nettype none

module station_temperature_line_parser #(
   parameter int unsigned QUEUE_DEPTH  = stlp_pkg::QUEUE_DEPTH,
   parameter int unsigned RESULT_DEPTH = stlp_pkg::RESULT_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire logic [7:0]         req_in_byte,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output logic        [63:0]      rsp_name_hash,
   output logic        [7:0]       rsp_name_length,
   output logic signed [10:0]      rsp_temp_tenths
);

   stlp_pkg::item_type     front_item;
   stlp_pkg::item_type     back_item;
   stlp_pkg::result_type   back_result;
   stlp_pkg::result_type   out_result;
   logic                   queue_push;
   logic                   queue_full;
   logic                   queue_empty;
   logic                   queue_pop;
   logic                   result_full;
   logic                   result_push;

   stlp_front u_front (
      .req_push    (req_push),
      .req_in_byte (req_in_byte),
      .req_full    (req_full),
      .queue_push  (queue_push),
      .queue_full  (queue_full),
      .queue_item  (front_item)
   );

   stlp_fifo #(
      .WIDTH ($bits(stlp_pkg::item_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (back_item)
   );

   stlp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (back_item),
      .queue_pop   (queue_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   stlp_fifo #(
      .WIDTH ($bits(stlp_pkg::result_type)),
      .DEPTH (RESULT_DEPTH)
   ) u_result (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (out_result)
   );

   assign rsp_name_hash   = out_result.name_hash;
   assign rsp_name_length = out_result.name_length;
   assign rsp_temp_tenths = out_result.temp_tenths;

endmodule

`default_nettype wire

// ===== hw/rtl/stlp_fifo.sv =====
`default_nettype none

module stlp_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  empty,
   output logic      [WIDTH-1:0] pop_data
);

   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stlp_front.sv =====
`default_nettype none

module stlp_front (
   input  wire logic                   req_push,
   input  wire logic [7:0]             req_in_byte,
   output logic                        req_full,
   output logic                        queue_push,
   input  wire logic                   queue_full,
   output stlp_pkg::item_type          queue_item
);

   // Carriage returns are taken from the stream and dropped here.
   assign req_full        = queue_full;
   assign queue_push      = req_push && (req_in_byte != stlp_pkg::CHAR_RETURN);
   assign queue_item.cls  = stlp_pkg::classify(req_in_byte);
   assign queue_item.data = req_in_byte;

endmodule

`default_nettype wire

// ===== hw/rtl/stlp_back.sv =====
`default_nettype none

module stlp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               queue_empty,
   input  wire stlp_pkg::item_type queue_item,
   output logic                    queue_pop,
   input  wire logic               result_full,
   output logic                    result_push,
   output stlp_pkg::result_type    result
);

   localparam logic [1:0] PH_NAME = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_DOT  = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [63:0] hash_ff, hash_in;
   logic [7:0]  length_ff, length_in;
   logic [9:0]  mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        is_newline;
   logic [9:0]  mag_final;
   logic [10:0] temp_abs;

   assign is_newline  = (queue_item.cls == stlp_pkg::CLS_NEWLINE);
   assign queue_pop   = !queue_empty && !(is_newline && result_full);
   assign result_push = queue_pop && is_newline;

   always_comb begin
      mag_final = mag_ff;
      if (phase_ff == PH_INT || phase_ff == PH_DOT) begin
         mag_final = stlp_pkg::mag_push(mag_ff, 4'd0);
      end
      temp_abs             = 11'(mag_final);
      result.name_hash     = hash_ff;
      result.name_length   = length_ff;
      result.temp_tenths   = (neg_ff && mag_final != '0) ? 11'(11'd0 - temp_abs) : temp_abs;
   end

   always_comb begin
      phase_in  = phase_ff;
      hash_in   = hash_ff;
      length_in = length_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      if (queue_pop) begin
         if (is_newline) begin
            phase_in  = PH_NAME;
            hash_in   = '0;
            length_in = '0;
            mag_in    = '0;
            neg_in    = 1'b0;
         end else begin
            case (phase_ff)
               PH_NAME: begin
                  if (queue_item.cls == stlp_pkg::CLS_SEMI) begin
                     phase_in = PH_INT;
                  end else begin
                     hash_in = (hash_ff << 5) - hash_ff + 64'(queue_item.data);
                     if (length_ff != 8'hFF) begin
                        length_in = length_ff + 1'b1;
                     end
                  end
               end
               PH_INT: begin
                  if (queue_item.cls == stlp_pkg::CLS_MINUS) begin
                     neg_in = 1'b1;
                  end else if (queue_item.cls == stlp_pkg::CLS_DOT) begin
                     phase_in = PH_DOT;
                  end else if (queue_item.cls == stlp_pkg::CLS_DIGIT) begin
                     mag_in = stlp_pkg::mag_push(mag_ff, queue_item.data[3:0]);
                  end
               end
               PH_DOT: begin
                  if (queue_item.cls == stlp_pkg::CLS_DIGIT) begin
                     mag_in   = stlp_pkg::mag_push(mag_ff, queue_item.data[3:0]);
                     phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_NAME;
         hash_ff   <= '0;
         length_ff <= '0;
         mag_ff    <= '0;
         neg_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         hash_ff   <= hash_in;
         length_ff <= length_in;
         mag_ff    <= mag_in;
         neg_ff    <= neg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/stlp_checker.sv =====
`default_nettype none

`include "station_temperature_line_parser_assert.svh"

module stlp_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_push,
   input wire logic               req_full,
   input wire logic               rsp_empty,
   input wire logic               rsp_pop,
   input wire logic        [63:0] rsp_name_hash,
   input wire logic        [7:0]  rsp_name_length,
   input wire logic signed [10:0] rsp_temp_tenths
);

   // A waiting result stays in place until it is popped.
   `STLP_ASSERT(result_holds, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_name_hash) && $stable(rsp_name_length) && $stable(rsp_temp_tenths))

   // An empty name always hashes to zero.
   `STLP_ASSERT(empty_name_zero_hash, clock, reset, !rsp_empty && rsp_name_length == 8'd0 |-> rsp_name_hash == 64'd0)

   // Temperatures stay within three digits of tenths.
   `STLP_ASSERT(temp_in_range, clock, reset, !rsp_empty |-> rsp_temp_tenths >= -11'sd999 && rsp_temp_tenths <= 11'sd999)

   // The request queue only fills up after a byte was offered.
   `STLP_ASSERT(full_needs_push, clock, reset, $rose(req_full) |-> $past(req_push))

   // Reset leaves no result behind.
   `STLP_ASSERT_ALWAYS(empty_after_reset, clock, $past(reset) |-> rsp_empty)

endmodule

bind station_temperature_line_parser stlp_checker u_checker (.*);

`default_nettype wire

// ===== tb/station_temperature_line_parser_checker.sv =====
`default_nettype none

module station_temperature_line_parser_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire logic               req_full,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               rsp_empty,
   input  wire logic               rsp_pop,
   input  wire logic [63:0]        rsp_name_hash,
   input  wire logic [7:0]         rsp_name_length,
   input  wire logic signed [10:0] rsp_temp_tenths,
   output int                      mismatches,
   output int                      outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      IN_NAME,
      IN_WHOLE,
      AFTER_POINT,
      FRACTION_TAKEN
   } line_phase_type;

   line_phase_type       cur_phase;
   logic [63:0]          hash_so_far;
   logic [7:0]           name_count;
   logic [9:0]           tenths_mag;
   logic                 is_negative;
   int                   error_tally;
   stlp_pkg::result_type expected_lines[$];

   function automatic logic [9:0] append_digit(input logic [9:0] mag, input logic [3:0] d);
      int v;
      v = int'(mag) * 10 + int'(d);
      return (v > int'(stlp_pkg::MAG_MAX)) ? stlp_pkg::MAG_MAX : 10'(v);
   endfunction

   task automatic clear_line();
      cur_phase   = IN_NAME;
      hash_so_far = '0;
      name_count  = '0;
      tenths_mag  = '0;
      is_negative = 1'b0;
   endtask

   task automatic fold_byte(input logic [7:0] b);
      logic                 is_digit;
      logic [9:0]           mag;
      logic signed [10:0]   t;
      stlp_pkg::result_type r;
      is_digit = (b >= stlp_pkg::CHAR_ZERO) && (b <= stlp_pkg::CHAR_NINE);
      if (b == stlp_pkg::CHAR_RETURN) begin
         return;
      end
      if (b == stlp_pkg::CHAR_NEWLINE) begin
         mag = tenths_mag;
         if (cur_phase == IN_WHOLE || cur_phase == AFTER_POINT) begin
            mag = append_digit(mag, 4'd0);
         end
         t = signed'(11'(mag));
         if (is_negative && mag != 0) begin
            t = -t;
         end
         r.name_hash   = hash_so_far;
         r.name_length = name_count;
         r.temp_tenths = t;
         expected_lines = {expected_lines, r};
         clear_line();
         return;
      end
      case (cur_phase)
         IN_NAME: begin
            if (b == stlp_pkg::CHAR_SEMI) begin
               cur_phase = IN_WHOLE;
            end else begin
               hash_so_far = hash_so_far * 64'd31 + 64'(b);
               if (name_count != 8'hFF) begin
                  name_count = name_count + 8'd1;
               end
            end
         end
         IN_WHOLE: begin
            if (b == stlp_pkg::CHAR_MINUS) begin
               is_negative = 1'b1;
            end else if (b == stlp_pkg::CHAR_DOT) begin
               cur_phase = AFTER_POINT;
            end else if (is_digit) begin
               tenths_mag = append_digit(tenths_mag, 4'(b - stlp_pkg::CHAR_ZERO));
            end
         end
         AFTER_POINT: begin
            if (is_digit) begin
               tenths_mag = append_digit(tenths_mag, 4'(b - stlp_pkg::CHAR_ZERO));
               cur_phase  = FRACTION_TAKEN;
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      stlp_pkg::result_type want;
      if (reset) begin
         clear_line();
         expected_lines.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_lines.size() == 0) begin
               $error("unexpected result: hash %h length %0d tenths %0d",
                      rsp_name_hash, rsp_name_length, rsp_temp_tenths);
               error_tally++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_name_hash !== want.name_hash) begin
                  $error("name_hash: expected %h, actual %h", want.name_hash, rsp_name_hash);
                  error_tally++;
               end
               if (rsp_name_length !== want.name_length) begin
                  $error("name_length: expected %0d, actual %0d",
                         want.name_length, rsp_name_length);
                  error_tally++;
               end
               if (rsp_temp_tenths !== want.temp_tenths) begin
                  $error("temp_tenths: expected %0d, actual %0d",
                         want.temp_tenths, rsp_temp_tenths);
                  error_tally++;
               end
            end
         end
         if (req_push && !req_full) begin
            fold_byte(req_in_byte);
         end
      end
      outstanding <= expected_lines.size();
      mismatches  <= error_tally;
   end

endmodule

`default_nettype wire

// ===== tb/station_temperature_line_parser_tb.sv =====
`default_nettype none

module station_temperature_line_parser_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 32;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_in_byte = 8'h00;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [63:0]        rsp_name_hash;
   logic [7:0]         rsp_name_length;
   logic signed [10:0] rsp_temp_tenths;
   int                 mismatches;
   int                 outstanding;
   int                 idle_pct = 0;
   int                 stall_pct = 0;
   int                 bytes_sent = 0;
   int                 cycle_count = 0;

   always #6 clock = ~clock;

   station_temperature_line_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_name_hash   (rsp_name_hash),
      .rsp_name_length (rsp_name_length),
      .rsp_temp_tenths (rsp_temp_tenths)
   );

   station_temperature_line_parser_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_name_hash   (rsp_name_hash),
      .rsp_name_length (rsp_name_length),
      .rsp_temp_tenths (rsp_temp_tenths),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(s[i]);
      end
   endtask

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == stlp_pkg::CHAR_NEWLINE || b == stlp_pkg::CHAR_SEMI);
      return b;
   endfunction

   function automatic logic [7:0] digit_byte();
      return stlp_pkg::CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   task automatic send_name(input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(name_byte());
      end
   endtask

   task automatic send_reading();
      int whole_digits;
      whole_digits = ($urandom_range(19) == 0) ? 3 : $urandom_range(1, 2);
      send_name($urandom_range(1, 16));
      push_byte(stlp_pkg::CHAR_SEMI);
      if ($urandom_range(1)) begin
         push_byte(stlp_pkg::CHAR_MINUS);
      end
      for (int i = 0; i < whole_digits; i++) begin
         push_byte(digit_byte());
      end
      push_byte(stlp_pkg::CHAR_DOT);
      push_byte(digit_byte());
      if ($urandom_range(4) == 0) begin
         push_byte(stlp_pkg::CHAR_RETURN);
      end
      push_byte(stlp_pkg::CHAR_NEWLINE);
   endtask

   task automatic send_noise();
      int         count;
      logic [7:0] b;
      count = $urandom_range(0, 20);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5))
            0: b = digit_byte();
            1: b = stlp_pkg::CHAR_MINUS;
            2: b = stlp_pkg::CHAR_DOT;
            3: b = stlp_pkg::CHAR_SEMI;
            4: b = stlp_pkg::CHAR_RETURN;
            default: begin
               do begin
                  b = 8'($urandom_range(255));
               end while (b == stlp_pkg::CHAR_NEWLINE);
            end
         endcase
         push_byte(b);
      end
      push_byte(stlp_pkg::CHAR_NEWLINE);
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text("a;1.2\n");
      send_text("Ab;-12.3\n");
      send_text("\n");
      send_text("xy\n");
      send_text("q;-0.0\n");
      send_text("q;5\n");
      send_text("q;-7.\n");
      send_text("q;123.4\n");
      send_text("q;9.99\n");
      send_text("q;1-2.3\n");
      send_text("q;.-5;x\n");
      send_text("r\015;1\015.5\015\015\n");
      send_text("q;99.9\n");
      send_text("q;-99.9\n");
      push_byte(8'h00);
      push_byte(8'hFF);
      send_text(";-9.9\015\n");
      send_name(260);
      send_text(";4.2\n");

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 76;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 76;
            end
            default: begin
               idle_pct = 30;
               stall_pct <= 30;
            end
         endcase
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            if ($urandom_range(99) < 85) begin
               send_reading();
            end else begin
               send_noise();
            end
         end
      end
      send_text("tail;1");

      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (16) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
